[design/kwf_pkg.sv]
// Shared types and constants for the IPv4 payload keyword filter.
package kwf_pkg;

  // Frame layout
  localparam int unsigned ETH_HDR_LEN = 14;
  localparam int unsigned MIN_IP_HDR  = 20;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [3:0]  IP_VERSION_4 = 4'd4;
  localparam logic [15:0] FRAG_MASK = 16'h2000 | 16'h1FFF;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  IHL_MASK = 8'h0F;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // Configuration
  localparam int unsigned KEYWORD_BYTES_DEF = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [31:0] KEYWORD_RESET = 32'h666C6167;  // "flag"
  localparam logic [7:0]  MARKER_RESET = 8'h25;          // '%'
  localparam logic CFG_IDX_KEYWORD = 1'b0;
  localparam logic CFG_IDX_MARKER  = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_PASS   = 2'd0,
    VERDICT_DROP   = 2'd1,
    VERDICT_ACCEPT = 2'd2
  } verdict_e;

  // Header fields of the current frame, including the current byte
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] ether_kind;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [15:0] tot_len;
  } hdr_fields_t;

endpackage

[design/kwf_in_if.sv]
// Input byte stream channel.
interface kwf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

[design/kwf_out_if.sv]
// Verdict output channel.
interface kwf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink (input valid, input verdict, output ready);
endinterface

[design/kwf_parse.sv]
// Byte position counter and header field capture.
module kwf_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                last_i,
  input  logic [7:0]          frame_byte_i,
  output kwf_pkg::hdr_fields_t fields_o,
  output logic                in_region_o
);

  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_VER_IHL  = 16'd14;
  localparam logic [15:0] POS_LEN_HI   = 16'd16;
  localparam logic [15:0] POS_LEN_LO   = 16'd17;
  localparam logic [15:0] POS_FRAG_HI  = 16'd20;
  localparam logic [15:0] POS_FRAG_LO  = 16'd21;
  localparam logic [15:0] POS_PROTO    = 16'd23;

  kwf_pkg::hdr_fields_t fields_q, fields_d;
  logic [5:0]  hdr_len;
  logic [16:0] region_lo, region_hi;

  // Capture header fields on their byte positions; position saturates
  always_comb begin
    fields_d = fields_q;
    case (fields_q.pos)
      POS_ETYPE_HI: fields_d.ether_kind = {frame_byte_i, 8'h00};
      POS_ETYPE_LO: fields_d.ether_kind[7:0] = fields_q.ether_kind[7:0] | frame_byte_i;
      POS_VER_IHL: begin
        fields_d.ip_version   = frame_byte_i[7:4];
        fields_d.header_words = 4'(frame_byte_i & kwf_pkg::IHL_MASK);
      end
      POS_LEN_HI:   fields_d.tot_len = {frame_byte_i, 8'h00};
      POS_LEN_LO:   fields_d.tot_len[7:0] = fields_q.tot_len[7:0] | frame_byte_i;
      POS_FRAG_HI:  fields_d.frag = {frame_byte_i, 8'h00};
      POS_FRAG_LO:  fields_d.frag[7:0] = fields_q.frag[7:0] | frame_byte_i;
      POS_PROTO:    fields_d.proto = frame_byte_i;
      default: ;
    endcase
    if (fields_q.pos != kwf_pkg::POS_MAX) begin
      fields_d.pos = fields_q.pos + 16'd1;
    end
  end

  // Fields seen by the current byte: captures applied, position of this byte
  always_comb begin
    fields_o     = fields_d;
    fields_o.pos = fields_q.pos;
  end

  // Region: 14 + IHL*4 <= pos < 14 + total length, with IHL*4 >= 20.
  // Region bytes sit past the header fields, so the stored values serve.
  assign hdr_len   = {fields_q.header_words, 2'b00};
  assign region_lo = 17'(kwf_pkg::ETH_HDR_LEN) + 17'(hdr_len);
  assign region_hi = 17'(kwf_pkg::ETH_HDR_LEN) + 17'(fields_q.tot_len);
  assign in_region_o = (hdr_len >= 6'(kwf_pkg::MIN_IP_HDR)) &&
                       (17'(fields_q.pos) >= region_lo) &&
                       (17'(fields_q.pos) < region_hi);

  // Field registers; cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fields_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        fields_q <= '0;
      end else begin
        fields_q <= fields_d;
      end
    end
  end

endmodule

[design/kwf_scan.sv]
// Payload history window with keyword and marker match.
module kwf_scan #(
  parameter int unsigned KeywordBytes = kwf_pkg::KEYWORD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        last_i,
  input  logic        in_region_i,
  input  logic [7:0]  frame_byte_i,
  input  logic [31:0] keyword_i,
  input  logic [7:0]  marker_i,
  output logic        hit_o
);

  localparam int unsigned HistW = (KeywordBytes > 1) ? 8 * (KeywordBytes - 1) : 8;
  localparam int unsigned WinW  = 8 * KeywordBytes;
  localparam int unsigned CntW  = (KeywordBytes > 1) ? $clog2(KeywordBytes) : 1;
  localparam logic [CntW-1:0] CntFull = CntW'(KeywordBytes - 1);

  logic [HistW-1:0]  hist_q, hist_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              kw_hit_q, kw_hit_d;
  logic              mk_hit_q, mk_hit_d;
  logic [HistW+7:0]  win_full;
  logic [WinW-1:0]   win, kw_masked;
  logic [63:0]       kw_ext;

  assign win_full  = {hist_q, frame_byte_i};
  assign win       = win_full[WinW-1:0];
  assign kw_ext    = {32'd0, keyword_i};
  assign kw_masked = kw_ext[WinW-1:0];

  // Window shift and match on region bytes
  always_comb begin
    hist_d   = hist_q;
    cnt_d    = cnt_q;
    kw_hit_d = kw_hit_q;
    mk_hit_d = mk_hit_q;
    if (in_region_i) begin
      if (frame_byte_i == marker_i) mk_hit_d = 1'b1;
      if ((cnt_q == CntFull) && (win == kw_masked)) kw_hit_d = 1'b1;
      hist_d = win_full[HistW-1:0];
      if (cnt_q != CntFull) cnt_d = cnt_q + CntW'(1);
    end
  end

  assign hit_o = kw_hit_d | mk_hit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      cnt_q    <= '0;
      kw_hit_q <= 1'b0;
      mk_hit_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        hist_q   <= '0;
        cnt_q    <= '0;
        kw_hit_q <= 1'b0;
        mk_hit_q <= 1'b0;
      end else begin
        hist_q   <= hist_d;
        cnt_q    <= cnt_d;
        kw_hit_q <= kw_hit_d;
        mk_hit_q <= mk_hit_d;
      end
    end
  end

endmodule

[design/kwf_decide.sv]
// Verdict decision from the final header fields and match flags.
module kwf_decide (
  input  kwf_pkg::hdr_fields_t fields_i,
  input  logic                 hit_i,
  output kwf_pkg::verdict_e    verdict_o
);

  logic [16:0] n_len, hdr_len, tot_len, frame_end, hdr_end;

  assign n_len     = 17'(fields_i.pos) + 17'd1;
  assign hdr_len   = 17'({fields_i.header_words, 2'b00});
  assign tot_len   = 17'(fields_i.tot_len);
  assign frame_end = 17'(kwf_pkg::ETH_HDR_LEN) + tot_len;
  assign hdr_end   = 17'(kwf_pkg::ETH_HDR_LEN) + hdr_len;

  // Priority chain of checks
  always_comb begin
    if (n_len < 17'(kwf_pkg::ETH_HDR_LEN)) begin
      verdict_o = kwf_pkg::VERDICT_PASS;
    end else if (fields_i.ether_kind == kwf_pkg::ETYPE_IPV6) begin
      verdict_o = kwf_pkg::VERDICT_DROP;
    end else if (fields_i.ether_kind != kwf_pkg::ETYPE_IPV4) begin
      verdict_o = kwf_pkg::VERDICT_PASS;
    end else if (n_len < 17'(kwf_pkg::ETH_HDR_LEN + kwf_pkg::MIN_IP_HDR) ||
                 fields_i.ip_version != kwf_pkg::IP_VERSION_4 ||
                 hdr_len < 17'(kwf_pkg::MIN_IP_HDR) ||
                 hdr_end > n_len) begin
      verdict_o = kwf_pkg::VERDICT_PASS;
    end else if ((fields_i.frag & kwf_pkg::FRAG_MASK) != 16'd0) begin
      verdict_o = kwf_pkg::VERDICT_DROP;
    end else if (fields_i.proto != kwf_pkg::PROTO_TCP) begin
      verdict_o = kwf_pkg::VERDICT_PASS;
    end else if (hdr_len > tot_len) begin
      verdict_o = kwf_pkg::VERDICT_PASS;
    end else if (frame_end > 17'(kwf_pkg::POS_MAX)) begin
      verdict_o = kwf_pkg::VERDICT_DROP;
    end else if (tot_len > hdr_len && frame_end > n_len) begin
      // region runs past the frame end
      verdict_o = kwf_pkg::VERDICT_DROP;
    end else if (hit_i) begin
      verdict_o = kwf_pkg::VERDICT_DROP;
    end else begin
      verdict_o = kwf_pkg::VERDICT_ACCEPT;
    end
  end

endmodule

[design/ipv4_payload_keyword_filter_core.sv]
// Top level of the IPv4 payload keyword filter.
//
//  Channel   Dir  Payload                 Handshake
//  rx_i      in   frame_byte, last_byte   valid/ready
//  tx_o      out  verdict (on last byte)  valid/ready
//  cfg       in   cfg_idx_i, cfg_data_i   cfg_we_i, no ready
//
// One byte per cycle; a byte enters the input register and is parsed and
// matched in the following cycle, and a verdict is loaded into the output
// register when its last byte leaves the input register. The input stalls
// only when a last byte waits behind an unclaimed verdict. Reset clears
// frame state and loads the default keyword and marker byte.
module ipv4_payload_keyword_filter_core #(
  parameter int unsigned KeywordBytes = kwf_pkg::KEYWORD_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  kwf_in_if.sink                         rx_i,
  kwf_out_if.source                      tx_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [kwf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        advance;
  logic        rx_accept;
  logic        out_valid_q;
  kwf_pkg::verdict_e verdict_q, verdict_d;
  logic [31:0] keyword_q;
  logic [7:0]  marker_q;

  kwf_pkg::hdr_fields_t fields;
  logic        in_region;
  logic        hit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword_q <= kwf_pkg::KEYWORD_RESET;
      marker_q  <= kwf_pkg::MARKER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kwf_pkg::CFG_IDX_KEYWORD: keyword_q <= cfg_data_i[31:0];
        kwf_pkg::CFG_IDX_MARKER:  marker_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // A byte in the input register moves on unless it is a last byte facing a full, unclaimed output slot
  assign advance   = in_valid_q && (!in_last_q || !out_valid_q || tx_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign rx_accept = rx_i.valid && rx_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_accept) begin
      in_byte_q <= rx_i.frame_byte;
      in_last_q <= rx_i.last_byte;
    end
  end

  kwf_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .last_i       (in_last_q),
    .frame_byte_i (in_byte_q),
    .fields_o     (fields),
    .in_region_o  (in_region)
  );

  kwf_scan #(
    .KeywordBytes (KeywordBytes)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .last_i       (in_last_q),
    .in_region_i  (in_region),
    .frame_byte_i (in_byte_q),
    .keyword_i    (keyword_q),
    .marker_i     (marker_q),
    .hit_o        (hit)
  );

  kwf_decide u_decide (
    .fields_i  (fields),
    .hit_i     (hit),
    .verdict_o (verdict_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (tx_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign tx_o.valid   = out_valid_q;
  assign tx_o.verdict = verdict_q;

`ifndef SYNTHESIS
  // A verdict appears only after a last byte was processed
  a_out_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_last_q))
    else $error("verdict without a last byte");

  // An unclaimed verdict is neither lost nor overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !tx_o.ready) |=> (out_valid_q && $stable(verdict_q)))
    else $error("pending verdict changed");

  // Input stalls only behind a last byte blocked by a full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> (in_valid_q && in_last_q && out_valid_q && !tx_o.ready))
    else $error("input stalled without cause");
`endif

endmodule
